// File: src/sbx_pkg.sv
// ----------------------------------------------------------------------------
// sbx_pkg
// shared types and constants for the serial buffer with xon/xoff flow control
// ----------------------------------------------------------------------------
`default_nettype none

package sbx_pkg;

    localparam int RX_DEPTH_DEF = 128;
    localparam int TX_DEPTH_DEF = 64;

    localparam logic [7:0] XON_CODE  = 8'h11;
    localparam logic [7:0] XOFF_CODE = 8'h13;

    // event modes
    localparam logic [2:0] MODE_RX_BYTE    = 3'd0;
    localparam logic [2:0] MODE_HOST_READ  = 3'd1;
    localparam logic [2:0] MODE_TX_SLOT    = 3'd2;
    localparam logic [2:0] MODE_HOST_WRITE = 3'd3;
    localparam logic [2:0] MODE_CLEAR_RX   = 3'd4;

    // realtime event codes
    localparam logic [2:0] EV_NONE   = 3'd0;
    localparam logic [2:0] EV_STATUS = 3'd1;
    localparam logic [2:0] EV_CYCLE  = 3'd2;
    localparam logic [2:0] EV_HOLD   = 3'd3;
    localparam logic [2:0] EV_DOOR   = 3'd4;
    localparam logic [2:0] EV_ABORT  = 3'd5;

    // configuration register indexes
    localparam logic [2:0] REG_STATUS_CHAR = 3'd0;
    localparam logic [2:0] REG_CYCLE_CHAR  = 3'd1;
    localparam logic [2:0] REG_HOLD_CHAR   = 3'd2;
    localparam logic [2:0] REG_DOOR_CHAR   = 3'd3;
    localparam logic [2:0] REG_ABORT_CHAR  = 3'd4;
    localparam logic [2:0] REG_HIGH_MARK   = 3'd5;
    localparam logic [2:0] REG_LOW_MARK    = 3'd6;
    localparam logic [2:0] REG_FLOW_EN     = 3'd7;

    typedef enum logic [1:0] {
        FS_XON_SENT  = 2'd0,
        FS_SEND_XOFF = 2'd1,
        FS_XOFF_SENT = 2'd2,
        FS_SEND_XON  = 2'd3
    } flow_state_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } ctrl_state_t;

    typedef struct packed {
        logic [2:0] rt_event;
        logic [6:0] high_mark;
        logic [6:0] low_mark;
        logic       flow_enable;
    } cfg_t;

    typedef struct packed {
        logic rd_en;
        logic push;
        logic pop;
        logic clear;
    } ring_ctl_t;

endpackage

`default_nettype wire

// File: src/serial_buffer_with_xon_xoff_unit.sv
// ----------------------------------------------------------------------------
// serial_buffer_with_xon_xoff_unit
// receive and transmit byte rings with realtime character pickoff and
// xon/xoff flow control
// ----------------------------------------------------------------------------
// sequence: the accepting edge registers the word and reads the ring memories;
// the execute state then updates the rings and the result register, and
// done pulses; no word is taken while executing. results cannot be stalled.
// reset: pointers cleared, flow state xon sent, registers at defaults; ring
// memory contents are not cleared and need no clearing pass.
`default_nettype none

module serial_buffer_with_xon_xoff_unit #(
    parameter int RX_DEPTH = sbx_pkg::RX_DEPTH_DEF,
    parameter int TX_DEPTH = sbx_pkg::TX_DEPTH_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [2:0] mode,
    input  wire logic [7:0] data_byte,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [2:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    output logic            done,
    output logic [7:0]      read_data,
    output logic            read_empty,
    output logic [7:0]      line_byte,
    output logic            line_byte_valid,
    output logic            write_accepted,
    output logic            rx_dropped,
    output logic [2:0]      realtime_event,
    output logic            tx_pending,
    output logic [6:0]      rx_level,
    output logic [5:0]      tx_level
);

    localparam int RX_PW = $clog2(RX_DEPTH);
    localparam int TX_PW = $clog2(TX_DEPTH);

    sbx_pkg::ctrl_state_t state_reg, state_next;
    sbx_pkg::flow_state_t flow_reg, flow_next;
    sbx_pkg::cfg_t        cfg;
    sbx_pkg::ring_ctl_t   rx_ctl, tx_ctl;

    logic [2:0]       mode_reg;
    logic [7:0]       data_reg;
    logic             accept;
    logic             exec;

    logic [7:0]       rx_rdata, tx_rdata;
    logic             rx_full, rx_empty, tx_full, tx_empty;
    logic [RX_PW-1:0] rx_lvl, rx_lvl_after;
    logic [TX_PW-1:0] tx_lvl, tx_lvl_after;
    logic [RX_PW+7:0] rx_lvl_ext, high_ext, low_ext;
    logic [TX_PW+7:0] tx_lvl_ext;

    logic             is_rx, is_rd, is_slot, is_wr, is_clr;
    logic [7:0]       rd_val, lb_val;
    logic             rempty_val, lbv_val, wacc_val, drop_val;
    logic [2:0]       ev_val;

    logic             done_reg;
    logic [7:0]       read_data_reg, line_byte_reg;
    logic             read_empty_reg, lbv_reg, wacc_reg, drop_reg, pend_reg;
    logic [2:0]       event_reg;
    logic [6:0]       rx_level_reg;
    logic [5:0]       tx_level_reg;

    // control sequencer
    always_comb
    begin
        case (state_reg)
            sbx_pkg::ST_IDLE: state_next = start ? sbx_pkg::ST_EXEC : sbx_pkg::ST_IDLE;
            sbx_pkg::ST_EXEC: state_next = sbx_pkg::ST_IDLE;
            default:          state_next = sbx_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        case (state_reg)
            sbx_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                exec = 1'b0;
            end
            sbx_pkg::ST_EXEC:
            begin
                busy = 1'b1;
                exec = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
                exec = 1'b0;
            end
        endcase
    end

    assign accept    = start && !busy;
    assign cfg_ready = !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sbx_pkg::ST_IDLE;
            flow_reg  <= sbx_pkg::FS_XON_SENT;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            flow_reg  <= flow_next;
            done_reg  <= exec;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= mode;
            data_reg <= data_byte;
        end
    end

    sbx_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (cfg_valid && cfg_ready),
        .wr_index   (cfg_index),
        .wr_data    (cfg_data),
        .match_byte (data_reg),
        .cfg        (cfg)
    );

    // event decode
    assign is_rx   = exec && (mode_reg == sbx_pkg::MODE_RX_BYTE);
    assign is_rd   = exec && (mode_reg == sbx_pkg::MODE_HOST_READ);
    assign is_slot = exec && (mode_reg == sbx_pkg::MODE_TX_SLOT);
    assign is_wr   = exec && (mode_reg == sbx_pkg::MODE_HOST_WRITE);
    assign is_clr  = exec && (mode_reg == sbx_pkg::MODE_CLEAR_RX);

    always_comb
    begin
        rx_ctl       = '0;
        tx_ctl       = '0;
        rx_ctl.rd_en = accept;
        tx_ctl.rd_en = accept;
        rd_val       = 8'd0;
        lb_val       = 8'd0;
        rempty_val   = 1'b0;
        lbv_val      = 1'b0;
        wacc_val     = 1'b0;
        drop_val     = 1'b0;
        ev_val       = sbx_pkg::EV_NONE;
        flow_next    = flow_reg;
        rx_lvl_after = rx_lvl;
        tx_lvl_after = tx_lvl;

        if (is_rx)
        begin
            ev_val = cfg.rt_event;
            if (cfg.rt_event == sbx_pkg::EV_NONE)
            begin
                if (rx_full)
                    drop_val = 1'b1;
                else
                begin
                    rx_ctl.push  = 1'b1;
                    rx_lvl_after = rx_lvl + 1'b1;
                end
            end
        end

        if (is_rd)
        begin
            if (rx_empty)
                rempty_val = 1'b1;
            else
            begin
                rx_ctl.pop   = 1'b1;
                rd_val       = rx_rdata;
                rx_lvl_after = rx_lvl - 1'b1;
            end
        end

        if (is_slot)
        begin
            if (flow_reg == sbx_pkg::FS_SEND_XOFF)
            begin
                lb_val    = sbx_pkg::XOFF_CODE;
                lbv_val   = 1'b1;
                flow_next = sbx_pkg::FS_XOFF_SENT;
            end
            else if (flow_reg == sbx_pkg::FS_SEND_XON)
            begin
                lb_val    = sbx_pkg::XON_CODE;
                lbv_val   = 1'b1;
                flow_next = sbx_pkg::FS_XON_SENT;
            end
            else if (!tx_empty)
            begin
                tx_ctl.pop   = 1'b1;
                lb_val       = tx_rdata;
                lbv_val      = 1'b1;
                tx_lvl_after = tx_lvl - 1'b1;
            end
        end

        if (is_wr && !tx_full)
        begin
            tx_ctl.push  = 1'b1;
            wacc_val     = 1'b1;
            tx_lvl_after = tx_lvl + 1'b1;
        end

        if (is_clr)
        begin
            rx_ctl.clear = 1'b1;
            rx_lvl_after = '0;
            flow_next    = sbx_pkg::FS_XON_SENT;
        end

        // flow marks on the level after the step
        if (rx_ctl.push && cfg.flow_enable && (rx_lvl_ext >= high_ext)
            && (flow_reg == sbx_pkg::FS_XON_SENT))
            flow_next = sbx_pkg::FS_SEND_XOFF;
        if (rx_ctl.pop && cfg.flow_enable && (rx_lvl_ext < low_ext)
            && (flow_reg == sbx_pkg::FS_XOFF_SENT))
            flow_next = sbx_pkg::FS_SEND_XON;
    end

    assign rx_lvl_ext = {8'd0, rx_lvl_after};
    assign tx_lvl_ext = {8'd0, tx_lvl_after};
    assign high_ext   = (RX_PW + 8)'(cfg.high_mark);
    assign low_ext    = (RX_PW + 8)'(cfg.low_mark);

    sbx_ring #(
        .DEPTH (RX_DEPTH)
    ) u_rx_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (rx_ctl),
        .wdata (data_reg),
        .rdata (rx_rdata),
        .full  (rx_full),
        .empty (rx_empty),
        .level (rx_lvl)
    );

    sbx_ring #(
        .DEPTH (TX_DEPTH)
    ) u_tx_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (tx_ctl),
        .wdata (data_reg),
        .rdata (tx_rdata),
        .full  (tx_full),
        .empty (tx_empty),
        .level (tx_lvl)
    );

    // result register
    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            read_data_reg  <= rd_val;
            read_empty_reg <= rempty_val;
            line_byte_reg  <= lb_val;
            lbv_reg        <= lbv_val;
            wacc_reg       <= wacc_val;
            drop_reg       <= drop_val;
            event_reg      <= ev_val;
            pend_reg       <= (flow_next == sbx_pkg::FS_SEND_XOFF)
                              || (flow_next == sbx_pkg::FS_SEND_XON)
                              || (tx_lvl_after != '0);
            rx_level_reg   <= rx_lvl_ext[6:0];
            tx_level_reg   <= tx_lvl_ext[5:0];
        end
    end

    assign done            = done_reg;
    assign read_data       = read_data_reg;
    assign read_empty      = read_empty_reg;
    assign line_byte       = line_byte_reg;
    assign line_byte_valid = lbv_reg;
    assign write_accepted  = wacc_reg;
    assign rx_dropped      = drop_reg;
    assign realtime_event  = event_reg;
    assign tx_pending      = pend_reg;
    assign rx_level        = rx_level_reg;
    assign tx_level        = tx_level_reg;

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not enter execution");

    a_single_exec: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("execution lasted more than one cycle");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without execution");

    a_no_double_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !(rx_ctl.pop && rx_ctl.push) && !(tx_ctl.pop && tx_ctl.push))
        else $error("ring pushed and popped by one word");

endmodule

`default_nettype wire

// File: src/sbx_cfg.sv
// ----------------------------------------------------------------------------
// sbx_cfg
// configuration registers and realtime character match
// ----------------------------------------------------------------------------
`default_nettype none

module sbx_cfg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire logic [2:0]    wr_index,
    input  wire logic [7:0]    wr_data,
    input  wire logic [7:0]    match_byte,
    output sbx_pkg::cfg_t      cfg
);

    logic [7:0] status_char_reg;
    logic [7:0] cycle_char_reg;
    logic [7:0] hold_char_reg;
    logic [7:0] door_char_reg;
    logic [7:0] abort_char_reg;
    logic [6:0] high_mark_reg;
    logic [6:0] low_mark_reg;
    logic       flow_en_reg;
    logic [2:0] rt_event;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_char_reg <= 8'd63;
            cycle_char_reg  <= 8'd126;
            hold_char_reg   <= 8'd33;
            door_char_reg   <= 8'd64;
            abort_char_reg  <= 8'd24;
            high_mark_reg   <= 7'd96;
            low_mark_reg    <= 7'd64;
            flow_en_reg     <= 1'b0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                sbx_pkg::REG_STATUS_CHAR: status_char_reg <= wr_data;
                sbx_pkg::REG_CYCLE_CHAR:  cycle_char_reg  <= wr_data;
                sbx_pkg::REG_HOLD_CHAR:   hold_char_reg   <= wr_data;
                sbx_pkg::REG_DOOR_CHAR:   door_char_reg   <= wr_data;
                sbx_pkg::REG_ABORT_CHAR:  abort_char_reg  <= wr_data;
                sbx_pkg::REG_HIGH_MARK:   high_mark_reg   <= wr_data[6:0];
                sbx_pkg::REG_LOW_MARK:    low_mark_reg    <= wr_data[6:0];
                sbx_pkg::REG_FLOW_EN:     flow_en_reg     <= wr_data[0];
                default: ;
            endcase
        end
    end

    // lowest event number wins on equal characters
    always_comb
    begin
        if (match_byte == status_char_reg)
            rt_event = sbx_pkg::EV_STATUS;
        else if (match_byte == cycle_char_reg)
            rt_event = sbx_pkg::EV_CYCLE;
        else if (match_byte == hold_char_reg)
            rt_event = sbx_pkg::EV_HOLD;
        else if (match_byte == door_char_reg)
            rt_event = sbx_pkg::EV_DOOR;
        else if (match_byte == abort_char_reg)
            rt_event = sbx_pkg::EV_ABORT;
        else
            rt_event = sbx_pkg::EV_NONE;
    end

    assign cfg.rt_event    = rt_event;
    assign cfg.high_mark   = high_mark_reg;
    assign cfg.low_mark    = low_mark_reg;
    assign cfg.flow_enable = flow_en_reg;

endmodule

`default_nettype wire

// File: src/sbx_ring.sv
// ----------------------------------------------------------------------------
// sbx_ring
// byte ring with one synchronous memory and head/tail pointers
// ----------------------------------------------------------------------------
`default_nettype none

module sbx_ring #(
    parameter int DEPTH = sbx_pkg::RX_DEPTH_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire sbx_pkg::ring_ctl_t         ctl,
    input  wire logic [7:0]                 wdata,
    output logic [7:0]                      rdata,
    output logic                            full,
    output logic                            empty,
    output logic [$clog2(DEPTH)-1:0]        level
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [PTR_W:0]   DEPTH_W = (PTR_W + 1)'(DEPTH);

    logic [7:0]       mem [DEPTH];
    logic [7:0]       rdata_reg;
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] tail_reg;
    logic [PTR_W-1:0] head_inc;
    logic [PTR_W-1:0] tail_inc;
    logic [PTR_W:0]   wrap_level;

    assign head_inc = (head_reg == LAST) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == LAST) ? '0 : tail_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (ctl.push)
            mem[head_reg] <= wdata;
        if (ctl.rd_en)
            rdata_reg <= mem[tail_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
        end
        else
        begin
            if (ctl.push)
                head_reg <= head_inc;
            if (ctl.clear)
                tail_reg <= head_reg;
            else if (ctl.pop)
                tail_reg <= tail_inc;
        end
    end

    assign wrap_level = {1'b0, head_reg} + DEPTH_W - {1'b0, tail_reg};

    assign level = (head_reg >= tail_reg) ? (head_reg - tail_reg) : wrap_level[PTR_W-1:0];
    assign full  = (head_inc == tail_reg);
    assign empty = (head_reg == tail_reg);
    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: dv/tb_serial_buffer_with_xon_xoff_unit.sv
// ----------------------------------------------------------------------------
// tb_serial_buffer_with_xon_xoff_unit
// drives receive, read, transmit, write and clear words into the serial buffer
// through a random-gap driver. a clocked monitor keeps its own model of both
// rings, the flow state and the registers, and compares every done result
// field by field. register settings change only between phases, once the
// block has drained.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_serial_buffer_with_xon_xoff_unit;

    localparam int STALL_LIMIT = 500;
    localparam int SETTLE_CYCLES = 4;
    localparam int QUIET_WORDS = 120;

    typedef enum logic [1:0] {
        OP_WORD,
        OP_REG,
        OP_SYNC
    } op_kind_t;

    typedef struct {
        op_kind_t   kind;
        logic [2:0] mode;
        logic [7:0] data;
        logic [2:0] idx;
    } op_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       read_empty;
        logic [7:0] line_byte;
        logic       line_byte_valid;
        logic       write_accepted;
        logic       rx_dropped;
        logic [2:0] realtime_event;
        logic       tx_pending;
        logic [6:0] rx_level;
        logic [5:0] tx_level;
    } buf_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic [2:0] mode = '0;
    logic [7:0] data_byte = '0;
    logic       cfg_valid = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;
    logic       busy;
    logic       cfg_ready;
    logic       done;
    logic [7:0] read_data;
    logic       read_empty;
    logic [7:0] line_byte;
    logic       line_byte_valid;
    logic       write_accepted;
    logic       rx_dropped;
    logic [2:0] realtime_event;
    logic       tx_pending;
    logic [6:0] rx_level;
    logic [5:0] tx_level;

    serial_buffer_with_xon_xoff_unit uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .mode            (mode),
        .data_byte       (data_byte),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .done            (done),
        .read_data       (read_data),
        .read_empty      (read_empty),
        .line_byte       (line_byte),
        .line_byte_valid (line_byte_valid),
        .write_accepted  (write_accepted),
        .rx_dropped      (rx_dropped),
        .realtime_event  (realtime_event),
        .tx_pending      (tx_pending),
        .rx_level        (rx_level),
        .tx_level        (tx_level)
    );

    // stimulus and expectations
    op_t         pending_ops[$];
    buf_result_t expected_results[$];
    logic [7:0]  stim_chars[0:4];
    int          quiet_from = 0;

    // buffer model
    logic [7:0]  rx_ring[0:sbx_pkg::RX_DEPTH_DEF-1];
    logic [7:0]  tx_ring[0:sbx_pkg::TX_DEPTH_DEF-1];
    logic [6:0]  rx_wr, rx_rd;
    logic [5:0]  tx_wr, tx_rd;
    sbx_pkg::flow_state_t flow;
    logic [7:0]  rt_char[0:4];
    logic [6:0]  hi_mark, lo_mark;
    logic        flow_on;

    // handshake flags and run statistics
    logic word_took = 1'b0;
    logic reg_took = 1'b0;
    int   gap_left = 0;
    int   settle_cnt = 0;
    int   words_issued = 0;
    int   words_in = 0;
    int   reg_writes = 0;
    int   stall_cycles = 0;
    int   check_failures = 0;
    int   drop_count = 0;
    int   refused_count = 0;
    int   flow_char_count = 0;
    int   event_count = 0;

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic buf_result_t buffer_step(input logic [2:0] m, input logic [7:0] d);
        buf_result_t r;
        logic [2:0]  ev;
        r = '0;
        ev = sbx_pkg::EV_NONE;
        case (m)
            sbx_pkg::MODE_RX_BYTE:
            begin
                for (int k = 4; k >= 0; k--)
                    if (d == rt_char[k])
                        ev = 3'(k + 1);
                if (ev != sbx_pkg::EV_NONE)
                begin
                    r.realtime_event = ev;
                    event_count++;
                end
                else if (7'(rx_wr + 7'd1) == rx_rd)
                begin
                    r.rx_dropped = 1'b1;
                    drop_count++;
                end
                else
                begin
                    rx_ring[rx_wr] = d;
                    rx_wr = 7'(rx_wr + 7'd1);
                    if (flow_on && 7'(rx_wr - rx_rd) >= hi_mark
                        && flow == sbx_pkg::FS_XON_SENT)
                        flow = sbx_pkg::FS_SEND_XOFF;
                end
            end
            sbx_pkg::MODE_HOST_READ:
            begin
                if (rx_wr == rx_rd)
                    r.read_empty = 1'b1;
                else
                begin
                    r.read_data = rx_ring[rx_rd];
                    rx_rd = 7'(rx_rd + 7'd1);
                    if (flow_on && 7'(rx_wr - rx_rd) < lo_mark
                        && flow == sbx_pkg::FS_XOFF_SENT)
                        flow = sbx_pkg::FS_SEND_XON;
                end
            end
            sbx_pkg::MODE_TX_SLOT:
            begin
                if (flow == sbx_pkg::FS_SEND_XOFF)
                begin
                    r.line_byte = sbx_pkg::XOFF_CODE;
                    r.line_byte_valid = 1'b1;
                    flow = sbx_pkg::FS_XOFF_SENT;
                    flow_char_count++;
                end
                else if (flow == sbx_pkg::FS_SEND_XON)
                begin
                    r.line_byte = sbx_pkg::XON_CODE;
                    r.line_byte_valid = 1'b1;
                    flow = sbx_pkg::FS_XON_SENT;
                    flow_char_count++;
                end
                else if (tx_wr != tx_rd)
                begin
                    r.line_byte = tx_ring[tx_rd];
                    r.line_byte_valid = 1'b1;
                    tx_rd = 6'(tx_rd + 6'd1);
                end
            end
            sbx_pkg::MODE_HOST_WRITE:
            begin
                if (6'(tx_wr + 6'd1) != tx_rd)
                begin
                    tx_ring[tx_wr] = d;
                    tx_wr = 6'(tx_wr + 6'd1);
                    r.write_accepted = 1'b1;
                end
                else
                    refused_count++;
            end
            sbx_pkg::MODE_CLEAR_RX:
            begin
                rx_rd = rx_wr;
                flow = sbx_pkg::FS_XON_SENT;
            end
            default:
            begin
            end
        endcase
        r.tx_pending = (flow == sbx_pkg::FS_SEND_XOFF || flow == sbx_pkg::FS_SEND_XON
                        || tx_wr != tx_rd);
        r.rx_level = 7'(rx_wr - rx_rd);
        r.tx_level = 6'(tx_wr - tx_rd);
        return r;
    endfunction

    function automatic void apply_reg(input logic [2:0] idx, input logic [7:0] v);
        case (idx)
            sbx_pkg::REG_STATUS_CHAR: rt_char[0] = v;
            sbx_pkg::REG_CYCLE_CHAR:  rt_char[1] = v;
            sbx_pkg::REG_HOLD_CHAR:   rt_char[2] = v;
            sbx_pkg::REG_DOOR_CHAR:   rt_char[3] = v;
            sbx_pkg::REG_ABORT_CHAR:  rt_char[4] = v;
            sbx_pkg::REG_HIGH_MARK:   hi_mark = v[6:0];
            sbx_pkg::REG_LOW_MARK:    lo_mark = v[6:0];
            sbx_pkg::REG_FLOW_EN:     flow_on = v[0];
            default:
            begin
            end
        endcase
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            check_failures++;
        end
    endtask

    // monitor: model update on accepted words and register writes, check on done
    always @(posedge clk or negedge rst_n)
    begin : monitor
        buf_result_t want;
        if (!rst_n)
        begin
            rx_wr = '0;
            rx_rd = '0;
            tx_wr = '0;
            tx_rd = '0;
            flow = sbx_pkg::FS_XON_SENT;
            rt_char[0] = 8'd63;
            rt_char[1] = 8'd126;
            rt_char[2] = 8'd33;
            rt_char[3] = 8'd64;
            rt_char[4] = 8'd24;
            hi_mark = 7'd96;
            lo_mark = 7'd64;
            flow_on = 1'b0;
            word_took <= 1'b0;
            reg_took <= 1'b0;
        end
        else
        begin
            word_took <= start && !busy;
            reg_took <= cfg_valid && cfg_ready;
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result word with nothing expected");
                    check_failures++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("read_data", want.read_data, read_data);
                    check_field("read_empty", want.read_empty, read_empty);
                    check_field("line_byte", want.line_byte, line_byte);
                    check_field("line_byte_valid", want.line_byte_valid, line_byte_valid);
                    check_field("write_accepted", want.write_accepted, write_accepted);
                    check_field("rx_dropped", want.rx_dropped, rx_dropped);
                    check_field("realtime_event", want.realtime_event, realtime_event);
                    check_field("tx_pending", want.tx_pending, tx_pending);
                    check_field("rx_level", want.rx_level, rx_level);
                    check_field("tx_level", want.tx_level, tx_level);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                apply_reg(cfg_index, cfg_data);
                reg_writes++;
            end
            if (start && !busy)
            begin
                expected_results.push_back(buffer_step(mode, data_byte));
                words_in++;
            end
            if (done || (start && !busy) || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // driver: feeds words and register writes from the pending queue
    always @(negedge clk)
    begin : driver
        op_t        op;
        logic       nx_start, nx_cfg_valid;
        logic [2:0] nx_mode, nx_idx;
        logic [7:0] nx_data, nx_cfg_data;
        nx_start = start;
        nx_mode = mode;
        nx_data = data_byte;
        nx_cfg_valid = cfg_valid;
        nx_idx = cfg_index;
        nx_cfg_data = cfg_data;
        if (rst_n)
        begin
            if (start && word_took)
                nx_start = 1'b0;
            if (cfg_valid && reg_took)
                nx_cfg_valid = 1'b0;
            if (!nx_start && !nx_cfg_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_ops.size() > 0)
                begin
                    op = pending_ops[0];
                    case (op.kind)
                        OP_WORD:
                        begin
                            if (words_issued < quiet_from && $urandom_range(0, 7) == 0)
                                gap_left = $urandom_range(0, 5);
                            else
                            begin
                                void'(pending_ops.pop_front());
                                nx_start = 1'b1;
                                nx_mode = op.mode;
                                nx_data = op.data;
                                words_issued++;
                            end
                        end
                        OP_REG:
                        begin
                            void'(pending_ops.pop_front());
                            nx_cfg_valid = 1'b1;
                            nx_idx = op.idx;
                            nx_cfg_data = op.data;
                        end
                        default:
                        begin
                            // hold off until the block has drained and settled
                            if (expected_results.size() != 0)
                                settle_cnt = 0;
                            else if (settle_cnt >= SETTLE_CYCLES)
                            begin
                                void'(pending_ops.pop_front());
                                settle_cnt = 0;
                            end
                            else
                                settle_cnt++;
                        end
                    endcase
                end
            end
        end
        start <= nx_start;
        mode <= nx_mode;
        data_byte <= nx_data;
        cfg_valid <= nx_cfg_valid;
        cfg_index <= nx_idx;
        cfg_data <= nx_cfg_data;
    end

    task automatic push_word(input logic [2:0] m, input logic [7:0] d);
        op_t op;
        op.kind = OP_WORD;
        op.mode = m;
        op.data = d;
        op.idx = '0;
        pending_ops.push_back(op);
    endtask

    task automatic push_reg(input logic [2:0] idx, input logic [7:0] d);
        op_t op;
        op.kind = OP_REG;
        op.mode = '0;
        op.data = d;
        op.idx = idx;
        pending_ops.push_back(op);
    endtask

    task automatic push_sync();
        op_t op;
        op.kind = OP_SYNC;
        op.mode = '0;
        op.data = '0;
        op.idx = '0;
        pending_ops.push_back(op);
    endtask

    task automatic program_regs(input logic [7:0] c0, c1, c2, c3, c4,
                                input logic [6:0] hi, lo, input logic fen);
        push_sync();
        push_reg(sbx_pkg::REG_STATUS_CHAR, c0);
        push_reg(sbx_pkg::REG_CYCLE_CHAR, c1);
        push_reg(sbx_pkg::REG_HOLD_CHAR, c2);
        push_reg(sbx_pkg::REG_DOOR_CHAR, c3);
        push_reg(sbx_pkg::REG_ABORT_CHAR, c4);
        push_reg(sbx_pkg::REG_HIGH_MARK, {1'($urandom), hi});
        push_reg(sbx_pkg::REG_LOW_MARK, {1'($urandom), lo});
        push_reg(sbx_pkg::REG_FLOW_EN, {7'($urandom), fen});
        stim_chars[0] = c0;
        stim_chars[1] = c1;
        stim_chars[2] = c2;
        stim_chars[3] = c3;
        stim_chars[4] = c4;
    endtask

    function automatic logic [2:0] pick_mode(input int w_rx, input int w_rd, input int w_tx);
        int r;
        r = $urandom_range(0, 99);
        if (r < 1)
            return sbx_pkg::MODE_CLEAR_RX;
        if (r < 3)
            return 3'($urandom_range(5, 7));
        r = $urandom_range(0, 99);
        if (r < w_rx)
            return sbx_pkg::MODE_RX_BYTE;
        if (r < w_rx + w_rd)
            return sbx_pkg::MODE_HOST_READ;
        if (r < w_rx + w_rd + w_tx)
            return sbx_pkg::MODE_TX_SLOT;
        return sbx_pkg::MODE_HOST_WRITE;
    endfunction

    task automatic add_random_words(input int n, input int w_rx, input int w_rd, input int w_tx);
        logic [2:0] m;
        logic [7:0] d;
        for (int i = 0; i < n; i++)
        begin
            m = pick_mode(w_rx, w_rd, w_tx);
            d = 8'($urandom);
            if (m == sbx_pkg::MODE_RX_BYTE && $urandom_range(0, 3) == 0)
                d = stim_chars[$urandom_range(0, 4)];
            push_word(m, d);
        end
    endtask

    initial
    begin
        // empty rings, byte extremes, realtime characters, unused modes, clear
        push_word(sbx_pkg::MODE_TX_SLOT, 8'h00);
        push_word(sbx_pkg::MODE_HOST_READ, 8'h00);
        push_word(sbx_pkg::MODE_HOST_WRITE, 8'h00);
        push_word(sbx_pkg::MODE_HOST_WRITE, 8'hFF);
        push_word(sbx_pkg::MODE_TX_SLOT, 8'h00);
        push_word(sbx_pkg::MODE_TX_SLOT, 8'h00);
        push_word(sbx_pkg::MODE_RX_BYTE, 8'h00);
        push_word(sbx_pkg::MODE_RX_BYTE, 8'hFF);
        push_word(sbx_pkg::MODE_RX_BYTE, 8'd63);
        push_word(sbx_pkg::MODE_RX_BYTE, 8'd126);
        push_word(sbx_pkg::MODE_RX_BYTE, 8'd33);
        push_word(sbx_pkg::MODE_RX_BYTE, 8'd64);
        push_word(sbx_pkg::MODE_RX_BYTE, 8'd24);
        push_word(sbx_pkg::MODE_HOST_READ, 8'h00);
        push_word(sbx_pkg::MODE_HOST_READ, 8'h00);
        push_word(3'd5, 8'hAA);
        push_word(3'd6, 8'h55);
        push_word(3'd7, 8'hFF);
        push_word(sbx_pkg::MODE_RX_BYTE, 8'h5A);
        push_word(sbx_pkg::MODE_CLEAR_RX, 8'h00);

        // equal realtime characters, xoff then xon, flow char sent while disabled
        program_regs(8'h42, 8'h42, 8'h42, 8'h42, 8'h42, 7'd2, 7'd1, 1'b1);
        push_word(sbx_pkg::MODE_RX_BYTE, 8'h42);
        push_word(sbx_pkg::MODE_RX_BYTE, 8'h01);
        push_word(sbx_pkg::MODE_RX_BYTE, 8'h02);
        push_word(sbx_pkg::MODE_HOST_WRITE, 8'h77);
        push_word(sbx_pkg::MODE_TX_SLOT, 8'h00);
        push_word(sbx_pkg::MODE_HOST_READ, 8'h00);
        push_word(sbx_pkg::MODE_HOST_READ, 8'h00);
        push_sync();
        push_reg(sbx_pkg::REG_FLOW_EN, 8'hFE);
        push_word(sbx_pkg::MODE_TX_SLOT, 8'h00);
        push_word(sbx_pkg::MODE_TX_SLOT, 8'h00);

        // random phases weighted toward fill or drain, marks at their extremes and in between
        program_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     7'd127, 7'd0, 1'b1);
        add_random_words(150, 60, 10, 10);
        program_regs(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 7'd100, 7'd127, 1'b1);
        add_random_words(150, 55, 10, 10);
        program_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                     7'($urandom_range(1, 127)), 7'($urandom), 1'b1);
        add_random_words(140, 15, 45, 30);
        program_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     7'd0, 7'd20, 1'b1);
        add_random_words(140, 35, 30, 15);
        program_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     7'($urandom_range(1, 127)), 7'($urandom), 1'b0);
        add_random_words(140, 60, 10, 5);
        program_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     7'd50, 7'd30, 1'b1);
        add_random_words(140, 55, 15, 10);
        program_regs(8'd63, 8'd126, 8'd33, 8'd64, 8'd24, 7'd127, 7'd127, 1'b1);
        add_random_words(120, 10, 45, 35);

        foreach (pending_ops[i])
            if (pending_ops[i].kind == OP_WORD)
                quiet_from++;
        quiet_from = quiet_from - QUIET_WORDS;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        while (pending_ops.size() != 0 || start || cfg_valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d words and %0d register writes over fill, drain and clear phases",
                 words_in, reg_writes);
        $display("%0d bytes dropped, %0d writes refused, %0d flow chars, %0d realtime events",
                 drop_count, refused_count, flow_char_count, event_count);
        if (check_failures == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
